@@ sv/v2e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2e_pkg
// Shared constants, types and tables for the vector to euler angles block.
// ----------------------------------------------------------------------------
package v2e_pkg;

	localparam int DATA_W              = 62;
	localparam int ANG_W               = 32;
	localparam int TABLE_LEN           = 24;
	localparam int COMPONENT_BITS_DEF  = 18;
	localparam int ANGLE_BITS_DEF      = 16;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;
	localparam logic [ANG_W-1:0] HALF_TURN   = 32'h8000_0000;
	localparam logic [ANG_W-1:0] QUARTER_UP  = 32'h4000_0000;
	localparam logic [ANG_W-1:0] QUARTER_DN  = 32'hC000_0000;

	localparam logic [ANG_W-1:0] ATAN_Q32 [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic vert;
		logic fz_pos;
		logic up;
		logic zero1;
	} flags_t;

	typedef struct packed {
		flags_t                    f;
		logic signed [DATA_W-1:0]  fz_k;
		logic signed [DATA_W-1:0]  uz_k;
	} yaw_sb_t;

	typedef struct packed {
		flags_t                    f;
		logic                      zero2;
		logic [ANG_W-1:0]          yaw;
		logic signed [DATA_W-1:0]  left_k;
	} pitch_sb_t;

	typedef struct packed {
		flags_t                    f;
		logic                      zero2;
		logic                      zero3;
		logic [ANG_W-1:0]          yaw;
		logic [ANG_W-1:0]          pitch;
	} roll_sb_t;

endpackage

@@ sv/vector_to_euler_angles_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_euler_angles_top
// Forward and optional up vector to pitch, yaw and roll binary angles.
// ----------------------------------------------------------------------------
// One vector is taken per clock while s_tready is high, and each gives one
// result after passing three cordic pipelines in series (yaw, then pitch,
// then roll) plus input, gain multiply and output registers. The whole
// pipeline holds while a result waits at the output, so s_tready follows
// m_tready whenever m_tvalid is high.
module vector_to_euler_angles_top import v2e_pkg::*; #(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
	parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// fwd_x, fwd_y, fwd_z, up_x, up_y, up_z
	input  logic [((6*COMPONENT_BITS+7)/8)*8-1:0]     s_tdata,
	// up_present
	input  logic                                      s_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// pitch, yaw, roll
	output logic [((3*ANGLE_BITS+7)/8)*8-1:0]         m_tdata
);

	localparam int CB      = COMPONENT_BITS;
	localparam int SCALE   = 56 - COMPONENT_BITS;
	localparam int GW      = COMPONENT_BITS + 32 + SCALE;
	localparam int OUT_W   = ((3*ANGLE_BITS+7)/8)*8;
	localparam int YSB_W   = $bits(yaw_sb_t);
	localparam int PSB_W   = $bits(pitch_sb_t);
	localparam int RSB_W   = $bits(roll_sb_t);

	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// input register
	logic            v_s0;
	logic [6*CB-1:0] raw_s0;
	logic            up_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s0 <= s_tdata[6*CB-1:0];
			up_s0  <= s_tuser;
		end
	end

	// stage 1: decode, gain products, yaw cordic set-up
	logic signed [CB-1:0]     rfx, rfy, rfz, rux, ruy, ruz;
	logic signed [DATA_W-1:0] sfx, sfy, sux, suy;
	logic signed [CB+31:0]    prod_fz, prod_uz;
	logic signed [GW-1:0]     ext_fz, ext_uz;
	logic signed [DATA_W-1:0] c_x, c_y, c_fx, c_fy;
	logic                     c_vert, c_fz_pos, c_neg;

	assign rfx = raw_s0[0*CB +: CB];
	assign rfy = raw_s0[1*CB +: CB];
	assign rfz = raw_s0[2*CB +: CB];
	assign rux = raw_s0[3*CB +: CB];
	assign ruy = raw_s0[4*CB +: CB];
	assign ruz = raw_s0[5*CB +: CB];

	assign sfx = DATA_W'(rfx) <<< SCALE;
	assign sfy = DATA_W'(rfy) <<< SCALE;
	assign sux = DATA_W'(rux) <<< SCALE;
	assign suy = DATA_W'(ruy) <<< SCALE;

	assign prod_fz = rfz * GAIN_Q30;
	assign prod_uz = ruz * GAIN_Q30;
	assign ext_fz  = GW'(prod_fz) <<< SCALE;
	assign ext_uz  = GW'(prod_uz) <<< SCALE;

	assign c_vert   = (rfx == '0) && (rfy == '0);
	assign c_fz_pos = !rfz[CB-1] && (rfz != '0);

	always_comb begin
		c_fx = sux;
		c_fy = suy;
		if (!c_vert) begin
			c_x = sfx;
			c_y = sfy;
		end else if (!up_s0) begin
			c_x = '0;
			c_y = '0;
		end else if (c_fz_pos) begin
			c_x = -sux;
			c_y = -suy;
		end else begin
			c_x = sux;
			c_y = suy;
		end
		c_neg = c_x[DATA_W-1];
	end

	logic                     v_s1;
	logic signed [DATA_W-1:0] x_s1, y_s1, fx_s1, fy_s1;
	logic [ANG_W-1:0]         ang_s1;
	yaw_sb_t                  sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1          <= c_neg ? -c_x : c_x;
			y_s1          <= c_neg ? -c_y : c_y;
			fx_s1         <= c_neg ? -c_fx : c_fx;
			fy_s1         <= c_neg ? -c_fy : c_fy;
			ang_s1        <= c_neg ? HALF_TURN : '0;
			sb_s1.f.vert  <= c_vert;
			sb_s1.f.fz_pos <= c_fz_pos;
			sb_s1.f.up    <= up_s0;
			sb_s1.f.zero1 <= (c_x == '0) && (c_y == '0);
			sb_s1.fz_k    <= DATA_W'(ext_fz >>> 30);
			sb_s1.uz_k    <= DATA_W'(ext_uz >>> 30);
		end
	end

	// yaw cordic
	logic                     yv;
	logic signed [DATA_W-1:0] y_horiz, y_upx, y_left;
	logic [ANG_W-1:0]         y_ang;
	logic [YSB_W-1:0]         y_sb_bits;
	yaw_sb_t                  y_sb;

	v2e_cordic #(.STAGES(CORDIC_STAGES), .SB_W(YSB_W)) u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_x     (x_s1),
		.in_y     (y_s1),
		.in_fx    (fx_s1),
		.in_fy    (fy_s1),
		.in_ang   (ang_s1),
		.in_sb    (YSB_W'(sb_s1)),
		.out_valid(yv),
		.out_x    (y_horiz),
		.out_fx   (y_upx),
		.out_fy   (y_left),
		.out_ang  (y_ang),
		.out_sb   (y_sb_bits)
	);

	assign y_sb = yaw_sb_t'(y_sb_bits);

	// gain stage 1: pitch set-up and partial products of the left component
	logic signed [DATA_W-31:0] left_hi;
	logic [29:0]               left_lo;
	logic                      p_neg;

	assign left_hi = y_left[DATA_W-1:30];
	assign left_lo = y_left[29:0];
	assign p_neg   = y_horiz[DATA_W-1];

	logic                     v_g1;
	logic signed [DATA_W-1:0] x_g1, y_g1, fx_g1, fy_g1;
	logic [ANG_W-1:0]         ang_g1;
	logic signed [63:0]       hi_g1;
	logic [60:0]              lo_g1;
	flags_t                   f_g1;
	logic                     zero2_g1;
	logic [ANG_W-1:0]         yaw_g1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_g1 <= 1'b0;
		end else if (en) begin
			v_g1 <= yv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_g1     <= p_neg ? -y_horiz : y_horiz;
			y_g1     <= p_neg ? -y_sb.fz_k : y_sb.fz_k;
			fx_g1    <= p_neg ? -y_upx : y_upx;
			fy_g1    <= p_neg ? -y_sb.uz_k : y_sb.uz_k;
			ang_g1   <= p_neg ? HALF_TURN : '0;
			zero2_g1 <= (y_horiz == '0) && (y_sb.fz_k == '0);
			hi_g1    <= 64'(left_hi) * 64'(GAIN_Q30);
			lo_g1    <= 61'(left_lo) * 61'(GAIN_Q30);
			f_g1     <= y_sb.f;
			yaw_g1   <= y_ang;
		end
	end

	// gain stage 2: sum of partial products
	logic                     v_g2;
	logic signed [DATA_W-1:0] x_g2, y_g2, fx_g2, fy_g2;
	logic [ANG_W-1:0]         ang_g2;
	pitch_sb_t                sb_g2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_g2 <= 1'b0;
		end else if (en) begin
			v_g2 <= v_g1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_g2         <= x_g1;
			y_g2         <= y_g1;
			fx_g2        <= fx_g1;
			fy_g2        <= fy_g1;
			ang_g2       <= ang_g1;
			sb_g2.f      <= f_g1;
			sb_g2.zero2  <= zero2_g1;
			sb_g2.yaw    <= yaw_g1;
			sb_g2.left_k <= DATA_W'(hi_g1 + signed'({33'd0, lo_g1[60:30]}));
		end
	end

	// pitch cordic
	logic                     pv;
	logic signed [DATA_W-1:0] p_fy;
	logic [ANG_W-1:0]         p_ang;
	logic [PSB_W-1:0]         p_sb_bits;
	pitch_sb_t                p_sb;

	v2e_cordic #(.STAGES(CORDIC_STAGES), .SB_W(PSB_W)) u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_g2),
		.in_x     (x_g2),
		.in_y     (y_g2),
		.in_fx    (fx_g2),
		.in_fy    (fy_g2),
		.in_ang   (ang_g2),
		.in_sb    (PSB_W'(sb_g2)),
		.out_valid(pv),
		.out_x    (),
		.out_fx   (),
		.out_fy   (p_fy),
		.out_ang  (p_ang),
		.out_sb   (p_sb_bits)
	);

	assign p_sb = pitch_sb_t'(p_sb_bits);

	// roll cordic set-up
	logic r_neg;
	assign r_neg = p_fy[DATA_W-1];

	logic                     v_r;
	logic signed [DATA_W-1:0] x_r, y_r;
	logic [ANG_W-1:0]         ang_r;
	roll_sb_t                 sb_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r <= 1'b0;
		end else if (en) begin
			v_r <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_r        <= r_neg ? -p_fy : p_fy;
			y_r        <= r_neg ? -p_sb.left_k : p_sb.left_k;
			ang_r      <= r_neg ? HALF_TURN : '0;
			sb_r.f     <= p_sb.f;
			sb_r.zero2 <= p_sb.zero2;
			sb_r.zero3 <= (p_fy == '0) && (p_sb.left_k == '0);
			sb_r.yaw   <= p_sb.yaw;
			sb_r.pitch <= p_ang;
		end
	end

	// roll cordic
	logic                     rv;
	logic [ANG_W-1:0]         r_ang;
	logic [RSB_W-1:0]         r_sb_bits;
	roll_sb_t                 r_sb;

	v2e_cordic #(.STAGES(CORDIC_STAGES), .SB_W(RSB_W)) u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_r),
		.in_x     (x_r),
		.in_y     (y_r),
		.in_fx    ('0),
		.in_fy    ('0),
		.in_ang   (ang_r),
		.in_sb    (RSB_W'(sb_r)),
		.out_valid(rv),
		.out_x    (),
		.out_fx   (),
		.out_fy   (),
		.out_ang  (r_ang),
		.out_sb   (r_sb_bits)
	);

	assign r_sb = roll_sb_t'(r_sb_bits);

	// output stage: special cases and rounding to binary angles
	logic [ANG_W-1:0] fin_pitch, fin_yaw, fin_roll;
	logic [ANG_W-1:0] rnd_pitch, rnd_yaw, rnd_roll;

	localparam logic [ANG_W-1:0] HALF_LSB = ANG_W'(1) << (31 - ANGLE_BITS);

	always_comb begin
		if (r_sb.f.vert) begin
			fin_pitch = r_sb.f.fz_pos ? QUARTER_UP : QUARTER_DN;
		end else if (r_sb.zero2) begin
			fin_pitch = '0;
		end else begin
			fin_pitch = r_sb.pitch;
		end
		fin_yaw = r_sb.f.zero1 ? '0 : r_sb.yaw;
		if (r_sb.f.vert || !r_sb.f.up || r_sb.zero3) begin
			fin_roll = '0;
		end else begin
			fin_roll = '0 - r_ang;
		end
		rnd_pitch = fin_pitch + HALF_LSB;
		rnd_yaw   = fin_yaw + HALF_LSB;
		rnd_roll  = fin_roll + HALF_LSB;
	end

	logic [ANGLE_BITS-1:0] pitch_q, yaw_q, roll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= rv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= rnd_pitch[31 -: ANGLE_BITS];
			yaw_q   <= rnd_yaw[31 -: ANGLE_BITS];
			roll_q  <= rnd_roll[31 -: ANGLE_BITS];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({roll_q, yaw_q, pitch_q});

endmodule

@@ sv/v2e_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2e_cordic
// Pipelined vectoring cordic, one micro-rotation per stage, with a follower
// pair rotated alongside and a sideband carried with each item.
// ----------------------------------------------------------------------------
module v2e_cordic import v2e_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int SB_W   = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] in_x,
	input  logic signed [DATA_W-1:0] in_y,
	input  logic signed [DATA_W-1:0] in_fx,
	input  logic signed [DATA_W-1:0] in_fy,
	input  logic [ANG_W-1:0]         in_ang,
	input  logic [SB_W-1:0]          in_sb,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_fx,
	output logic signed [DATA_W-1:0] out_fy,
	output logic [ANG_W-1:0]         out_ang,
	output logic [SB_W-1:0]          out_sb
);

	logic                     v_s   [STAGES];
	logic signed [DATA_W-1:0] x_s   [STAGES];
	logic signed [DATA_W-1:0] y_s   [STAGES];
	logic signed [DATA_W-1:0] fx_s  [STAGES];
	logic signed [DATA_W-1:0] fy_s  [STAGES];
	logic [ANG_W-1:0]         ang_s [STAGES];
	logic [SB_W-1:0]          sb_s  [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_step
		logic                     vi;
		logic signed [DATA_W-1:0] xi, yi, fxi, fyi;
		logic [ANG_W-1:0]         ai;
		logic [SB_W-1:0]          sbi;

		if (i == 0) begin : g_first
			assign vi  = in_valid;
			assign xi  = in_x;
			assign yi  = in_y;
			assign fxi = in_fx;
			assign fyi = in_fy;
			assign ai  = in_ang;
			assign sbi = in_sb;
		end else begin : g_next
			assign vi  = v_s[i-1];
			assign xi  = x_s[i-1];
			assign yi  = y_s[i-1];
			assign fxi = fx_s[i-1];
			assign fyi = fy_s[i-1];
			assign ai  = ang_s[i-1];
			assign sbi = sb_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[i] <= sbi;
				if (!yi[DATA_W-1]) begin
					x_s[i]   <= xi + (yi >>> i);
					y_s[i]   <= yi - (xi >>> i);
					fx_s[i]  <= fxi + (fyi >>> i);
					fy_s[i]  <= fyi - (fxi >>> i);
					ang_s[i] <= ai + ATAN_Q32[i];
				end else begin
					x_s[i]   <= xi - (yi >>> i);
					y_s[i]   <= yi + (xi >>> i);
					fx_s[i]  <= fxi - (fyi >>> i);
					fy_s[i]  <= fyi + (fxi >>> i);
					ang_s[i] <= ai - ATAN_Q32[i];
				end
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_x     = x_s[STAGES-1];
	assign out_fx    = fx_s[STAGES-1];
	assign out_fy    = fy_s[STAGES-1];
	assign out_ang   = ang_s[STAGES-1];
	assign out_sb    = sb_s[STAGES-1];

endmodule

@@ sv/v2e_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2e_checker
// Port-level checks for the vector to euler angles block.
// ----------------------------------------------------------------------------
module v2e_checker #(
	parameter int OUT_W = 48
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output state");

	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result present right after reset");

endmodule

bind vector_to_euler_angles_top v2e_checker #(.OUT_W(OUT_W)) u_v2e_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ bench/tb_vector_to_euler_angles_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_to_euler_angles_top
// Streams forward/up vectors through the block and checks each pitch, yaw and
// roll against an integer cordic predictor, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_vector_to_euler_angles_top;
	import v2e_pkg::*;

	localparam int CB = COMPONENT_BITS_DEF;
	localparam int AB = ANGLE_BITS_DEF;
	localparam int NS = CORDIC_STAGES_DEF;
	localparam int SDW = ((6*CB+7)/8)*8;
	localparam int MDW = ((3*AB+7)/8)*8;
	localparam int LATENCY = 3*NS+6;
	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	typedef struct packed {
		logic [AB-1:0] roll;
		logic [AB-1:0] yaw;
		logic [AB-1:0] pitch;
	} angles_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [SDW-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [MDW-1:0] m_tdata;

	angles_t expected_angles[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_sink = 0;
	bit stall_sink_en = 1;
	int src_gap_max = 3;

	always #5 clk = ~clk;

	vector_to_euler_angles_top DUT (.*);

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint gain_mul(longint v);
		longint hi, lo;
		hi = v >>> 30;
		lo = v - (hi <<< 30);
		return hi * longint'(GAIN_Q30) + ((lo * longint'(GAIN_Q30)) >>> 30);
	endfunction

	function automatic longint widen(logic signed [CB-1:0] c);
		longint v;
		v = c;
		return v <<< (56 - CB);
	endfunction

	function automatic logic [31:0] cordic_atan(longint x, longint y, inout longint fx,
			inout longint fy, output longint mag);
		logic [31:0] a;
		longint dx, dy, ex, ey;
		a = 0;
		mag = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x; y = -y; fx = -fx; fy = -fy;
			a = HALF_TURN;
		end
		for (int i = 0; i < NS && i < TABLE_LEN; i++) begin
			dx = floor_sh(y, i); dy = floor_sh(x, i);
			ex = floor_sh(fy, i); ey = floor_sh(fx, i);
			if (y >= 0) begin
				x += dx; y -= dy; fx += ex; fy -= ey; a += ATAN_Q32[i];
			end else begin
				x -= dx; y += dy; fx -= ex; fy += ey; a -= ATAN_Q32[i];
			end
		end
		mag = x;
		return a;
	endfunction

	function automatic logic [AB-1:0] to_bam(logic [31:0] a);
		logic [31:0] r;
		r = a + (32'd1 << (31 - AB));
		return r[31 -: AB];
	endfunction

	function automatic angles_t predict_angles(logic signed [CB-1:0] c[6], logic up);
		longint fx, fy, fz, ux, uy, uz, m, horiz, left, dfx, dfy;
		logic [31:0] p, y, r;
		angles_t res;
		fx = widen(c[0]); fy = widen(c[1]); fz = widen(c[2]);
		ux = widen(c[3]); uy = widen(c[4]); uz = widen(c[5]);
		r = 0;
		dfx = 0; dfy = 0;
		if (fx == 0 && fy == 0) begin
			if (fz > 0) begin
				p = QUARTER_UP;
				y = up ? cordic_atan(-ux, -uy, dfx, dfy, m) : 0;
			end else begin
				p = QUARTER_DN;
				y = up ? cordic_atan(ux, uy, dfx, dfy, m) : 0;
			end
		end else begin
			y = cordic_atan(fx, fy, ux, uy, horiz);
			left = uy;
			uy = gain_mul(uz);
			p = cordic_atan(horiz, gain_mul(fz), ux, uy, m);
			if (up) r = 32'd0 - cordic_atan(uy, gain_mul(left), dfx, dfy, m);
		end
		res.pitch = to_bam(p);
		res.yaw = to_bam(y);
		res.roll = to_bam(r);
		return res;
	endfunction

	task automatic send_vector(logic signed [CB-1:0] c[6], logic up);
		logic [SDW-1:0] d;
		int gap;
		d = '0;
		for (int k = 0; k < 6; k++) d[k*CB +: CB] = c[k];
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		s_tuser <= up;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_angles.push_back(predict_angles(c, up));
	endtask

	task automatic send_row(int a, int b, int cc, int d, int e, int f, logic up);
		logic signed [CB-1:0] c[6];
		c[0] = CB'(a); c[1] = CB'(b); c[2] = CB'(cc);
		c[3] = CB'(d); c[4] = CB'(e); c[5] = CB'(f);
		send_vector(c, up);
	endtask

	function automatic logic signed [CB-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			3: return CB'($urandom_range(0, 8) - 4);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		s_tvalid <= 0;
		while (expected_angles.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_row(0, 0, 0, 0, 0, 0, 0);
		send_row(0, 0, 0, 0, 0, 0, 1);
		send_row(0, 0, 5, 3, -7, 1, 1);
		send_row(0, 0, 5, 3, -7, 1, 0);
		send_row(0, 0, -5, 3, -7, 1, 1);
		send_row(0, 0, int'(CMAX), 0, 0, 0, 1);
		send_row(0, 0, int'(CMIN), int'(CMIN), int'(CMAX), 0, 1);
		send_row(int'(CMAX), 0, 0, 0, 0, int'(CMAX), 1);
		send_row(int'(CMIN), 0, 0, 0, 0, int'(CMAX), 1);
		send_row(0, int'(CMAX), 0, 0, 0, 1, 1);
		send_row(0, int'(CMIN), 0, 0, 0, 1, 1);
		send_row(int'(CMIN), int'(CMIN), int'(CMIN), int'(CMIN), int'(CMIN), int'(CMIN), 1);
		send_row(int'(CMAX), int'(CMAX), int'(CMAX), int'(CMAX), int'(CMAX), int'(CMAX), 1);
		send_row(int'(CMAX), int'(CMIN), int'(CMAX), int'(CMIN), int'(CMAX), int'(CMIN), 0);
		send_row(1, 0, 0, 0, 0, 0, 1);
		send_row(-1, -1, 1, 0, 1, 0, 1);
		send_row(100, 200, 300, -1, 2, 9, 1);
		send_row(-3, 4, 0, 0, 0, 0, 1);
	endtask

	task automatic test_random(int n);
		logic signed [CB-1:0] c[6];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 6; k++) c[k] = rand_comp();
			if ($urandom_range(0, 9) == 0) begin
				c[0] = '0; c[1] = '0;
			end
			send_vector(c, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_backpressure();
		hold_sink = 1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_sink = 0;
			end
			test_random(150);
		join
		wait_drained();
	endtask

	task automatic test_streaming();
		stall_sink_en = 0;
		src_gap_max = 0;
		test_random(150);
		stall_sink_en = 1;
		src_gap_max = 3;
	endtask

	always @(posedge clk) begin
		if (!hold_sink && (!stall_sink_en || $urandom_range(0, 3) != 0))
			m_tready <= ($urandom_range(0, 49) != 0) || !stall_sink_en;
		else
			m_tready <= 0;
	end

	always @(posedge clk) begin
		angles_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[3*AB-1:0];
			if (expected_angles.size() == 0) begin
				$error("unexpected transfer %h", m_tdata);
				errors++;
			end else begin
				want = expected_angles.pop_front();
				if (got.pitch !== want.pitch) begin
					$error("pitch exp %0d got %0d", want.pitch, got.pitch); errors++;
				end
				if (got.yaw !== want.yaw) begin
					$error("yaw exp %0d got %0d", want.yaw, got.yaw); errors++;
				end
				if (got.roll !== want.roll) begin
					$error("roll exp %0d got %0d", want.roll, got.roll); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random(1032);
		test_backpressure();
		test_streaming();
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_angles.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
